>>> rtl/core/wst_pkg.sv
package wst_pkg;

  // Field widths
  localparam int unsigned TimeW  = 64;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned RateW  = 26;
  localparam int unsigned CountW = 32;
  localparam int unsigned NsW    = 30;
  localparam int unsigned ProdW  = CountW + NsW;
  localparam int unsigned NumW   = ProdW + 16;
  localparam int unsigned StepW  = 5;

  // Constants
  localparam logic [CfgW-1:0]  RESET_MIN_INTERVAL_NS = 32'd100000000;
  localparam logic [NsW-1:0]   NS_PER_S              = 30'd1000000000;
  localparam logic [RateW-1:0] HZ_Q16_MAX            = 26'd65536000;
  // one second in ns scaled by 2^16: numerator of the instant rate
  localparam logic [NumW-1:0]  INST_NUM              = {14'd0, 48'd1000000000, 16'd0};
  localparam logic [StepW-1:0] DIV_STEPS             = 5'd26;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul_load;
    logic div_step;
    logic avg_load;
    logic store_avg;
    logic write_out;
  } wst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rotation;
    logic first;
    logic div_done;
    logic out_free;
  } wst_sts_t;

endpackage

>>> rtl/core/wst_ctrl.sv
module wst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wst_pkg::wst_sts_t sts,
  output wst_pkg::wst_cmd_t cmd
);
  import wst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV_I,
    S_DIV_A,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.rotation) begin
          state_nxt = S_IDLE;
        end else if (sts.first) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DIV_I;
      end
      S_DIV_I: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_nxt    = S_DIV_A;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIV_A: begin
        if (sts.div_done) begin
          cmd.store_avg = 1'b1;
          state_nxt     = S_WRITE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_WRITE: begin
        if (sts.out_free) begin
          cmd.write_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_out |-> sts.out_free)
    else $error("result written while output register full");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("transfer not followed by evaluation");

endmodule

>>> rtl/core/wst_dpath.sv
module wst_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wst_pkg::CfgW-1:0]       cfg_wdata,
  input  logic [wst_pkg::TimeW-1:0]      in_irq_time_ns,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_speed_valid,
  output logic [wst_pkg::RateW-1:0]      out_instant_hz_q16,
  output logic [wst_pkg::RateW-1:0]      out_average_hz_q16,
  output logic [wst_pkg::CountW-1:0]     out_rotations,
  output logic [wst_pkg::TimeW-1:0]      out_rotation_time_ns,
  input  wst_pkg::wst_cmd_t              cmd,
  output wst_pkg::wst_sts_t              sts
);
  import wst_pkg::*;

  logic [CfgW-1:0]   min_r;
  logic              parity_r, odd_r, have_first_r;
  logic [TimeW-1:0]  t_r, last_r, first_r, dt_r, el_r;
  logic [CountW-1:0] count_r;
  logic [ProdW-1:0]  prod_r;
  logic [RateW-1:0]  inst_r, avg_r;
  logic              spd_r;

  // divider state
  logic [TimeW-1:0]  rem_r, d_r;
  logic [RateW-1:0]  nlo_r, q_r;
  logic [StepW-1:0]  cnt_r;
  logic              sat_r;

  logic              out_valid_r, out_spd_r;
  logic [RateW-1:0]  out_inst_r, out_avg_r;
  logic [CountW-1:0] out_rot_r;
  logic [TimeW-1:0]  out_time_r;

  logic [TimeW-1:0]  since_last;
  logic              rotation;
  logic [NumW-1:0]   num;
  logic [TimeW-1:0]  den;
  logic [TimeW:0]    rem_sh;
  logic              fits;
  logic [RateW-1:0]  rate;
  logic              out_free;

  // Acceptance test on the held timestamp
  assign since_last = t_r - last_r;
  assign rotation   = odd_r && (t_r > last_r) && (since_last > {32'd0, min_r});

  // Divider operands and one restoring step
  assign num    = cmd.avg_load ? {prod_r, 16'd0} : INST_NUM;
  assign den    = cmd.avg_load ? el_r : dt_r;
  assign rem_sh = {rem_r, nlo_r[RateW-1]};
  assign fits   = rem_sh >= {1'b0, d_r};
  assign rate   = (sat_r || (q_r > HZ_Q16_MAX)) ? HZ_Q16_MAX : q_r;

  assign out_free = !out_valid_r || out_ready;

  assign sts.rotation = rotation;
  assign sts.first    = !have_first_r;
  assign sts.div_done = (cnt_r == DIV_STEPS);
  assign sts.out_free = out_free;

  // Control state: configuration, parity, rotation history, output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r        <= RESET_MIN_INTERVAL_NS;
      parity_r     <= 1'b0;
      odd_r        <= 1'b0;
      have_first_r <= 1'b0;
      last_r       <= '0;
      first_r      <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_r <= cfg_wdata;
      end
      if (cmd.load_in) begin
        parity_r <= ~parity_r;
        odd_r    <= ~parity_r;
      end
      if (cmd.eval && rotation) begin
        last_r <= t_r;
        if (!have_first_r) begin
          have_first_r <= 1'b1;
          first_r      <= t_r;
          count_r      <= '0;
        end else if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.write_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: timestamp, intervals, product, rates and output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_r <= in_irq_time_ns;
    end
    if (cmd.eval && rotation) begin
      dt_r <= since_last;
      el_r <= t_r - first_r;
      spd_r <= have_first_r;
      if (!have_first_r) begin
        inst_r <= '0;
        avg_r  <= '0;
      end
    end
    if (cmd.mul_load) begin
      prod_r <= ProdW'(count_r) * ProdW'(NS_PER_S);
    end
    if (cmd.avg_load) begin
      inst_r <= rate;
    end
    if (cmd.store_avg) begin
      avg_r <= rate;
    end
    if (cmd.write_out) begin
      out_spd_r  <= spd_r;
      out_inst_r <= inst_r;
      out_avg_r  <= avg_r;
      out_rot_r  <= count_r;
      out_time_r <= last_r;
    end
  end

  // Shared divider: load numerator top, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= DIV_STEPS;
    end else if (cmd.mul_load || cmd.avg_load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load || cmd.avg_load) begin
      rem_r <= {12'd0, num[NumW-1:RateW]};
      nlo_r <= num[RateW-1:0];
      d_r   <= den;
      q_r   <= '0;
      sat_r <= {12'd0, num[NumW-1:RateW]} >= den;
    end else if (cmd.div_step) begin
      rem_r <= fits ? TimeW'(rem_sh - {1'b0, d_r}) : rem_sh[TimeW-1:0];
      nlo_r <= {nlo_r[RateW-2:0], 1'b0};
      q_r   <= {q_r[RateW-2:0], fits};
    end
  end

  assign out_valid            = out_valid_r;
  assign out_speed_valid      = out_spd_r;
  assign out_instant_hz_q16   = out_inst_r;
  assign out_average_hz_q16   = out_avg_r;
  assign out_rotations        = out_rot_r;
  assign out_rotation_time_ns = out_time_r;

  a_rate_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_inst_r <= HZ_Q16_MAX) && (out_avg_r <= HZ_Q16_MAX))
    else $error("rate above saturation limit");

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_spd_r) |-> (out_inst_r == '0) && (out_rot_r == '0))
    else $error("first rotation carries non-zero rate or count");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DIV_STEPS)
    else $error("divider step count overrun");

endmodule

>>> rtl/core/wheel_speed_tachometer.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   irq_time_ns
// out_      output     out_valid / out_ready speed_valid, rates, rotations, time
// cfg_      input      cfg_we                min_interval_ns
//
// An interrupt that is not a rotation returns to idle after evaluation; a first
// rotation goes to the write, plus output wait; later rotations run the shared
// one-bit-per-cycle divider twice (26 steps each, instant then average).
// Reset (synchronous, rst_n low) clears history and loads min interval 100 ms.
// A new interrupt is taken while a finished result still waits in the output
// register; a rotation stalls before writing only if that register is full.
module wheel_speed_tachometer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wst_pkg::CfgW-1:0]       cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wst_pkg::TimeW-1:0]      in_irq_time_ns,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_speed_valid,
  output logic [wst_pkg::RateW-1:0]      out_instant_hz_q16,
  output logic [wst_pkg::RateW-1:0]      out_average_hz_q16,
  output logic [wst_pkg::CountW-1:0]     out_rotations,
  output logic [wst_pkg::TimeW-1:0]      out_rotation_time_ns
);
  import wst_pkg::*;

  wst_cmd_t cmd;
  wst_sts_t sts;

  // Sequence each transfer through evaluation and division
  wst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold history, divide and register the result
  wst_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_irq_time_ns       (in_irq_time_ns),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_speed_valid      (out_speed_valid),
    .out_instant_hz_q16   (out_instant_hz_q16),
    .out_average_hz_q16   (out_average_hz_q16),
    .out_rotations        (out_rotations),
    .out_rotation_time_ns (out_rotation_time_ns),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wst_pkg::*;

  localparam int unsigned LATENCY_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [127:0] SCALED_SECOND = 128'd65536000000000;
  localparam logic [CfgW-1:0] MIN_INTERVAL_LOW  = 32'd1000000;
  localparam logic [CfgW-1:0] MIN_INTERVAL_HIGH = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              speed_valid;
    logic [RateW-1:0]  instant_hz_q16;
    logic [RateW-1:0]  average_hz_q16;
    logic [CountW-1:0] rotations;
    logic [TimeW-1:0]  rotation_time_ns;
  } rotation_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CfgW-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TimeW-1:0]  in_irq_time_ns = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_speed_valid;
  logic [RateW-1:0]  out_instant_hz_q16;
  logic [RateW-1:0]  out_average_hz_q16;
  logic [CountW-1:0] out_rotations;
  logic [TimeW-1:0]  out_rotation_time_ns;

  // Tachometer state as predicted
  logic [CfgW-1:0]   min_interval = RESET_MIN_INTERVAL_NS;
  logic              edge_par = 1'b0;
  logic [TimeW-1:0]  last_rot = '0;
  logic [TimeW-1:0]  first_rot = '0;
  logic              have_first = 1'b0;
  logic [CountW-1:0] rot_count = '0;

  rotation_report_t  pending_reports[$];
  rotation_report_t  want_report;
  rotation_report_t  got_report;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  wheel_speed_tachometer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_irq_time_ns       (in_irq_time_ns),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_speed_valid      (out_speed_valid),
    .out_instant_hz_q16   (out_instant_hz_q16),
    .out_average_hz_q16   (out_average_hz_q16),
    .out_rotations        (out_rotations),
    .out_rotation_time_ns (out_rotation_time_ns)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abandon a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wheel_speed_tachometer regression: fail");
      $finish;
    end
  end

  // Rate in Q.16 hertz: count seconds over span ns, truncated and saturated
  function automatic logic [RateW-1:0] hz_q16(input logic [CountW-1:0] count,
                                              input logic [TimeW-1:0] span);
    logic [127:0] quotient;
    quotient = ({96'd0, count} * SCALED_SECOND) / {64'd0, span};
    if (quotient > {102'd0, HZ_Q16_MAX})
      return HZ_Q16_MAX;
    return quotient[RateW-1:0];
  endfunction

  // Advance the predicted state by one interrupt; queue any rotation report
  task automatic predict_irq(input logic [TimeW-1:0] stamp);
    logic              odd_edge;
    logic [TimeW-1:0]  dt;
    rotation_report_t  rep;
    odd_edge = !edge_par;
    edge_par = !edge_par;
    if (odd_edge && stamp > last_rot && (stamp - last_rot) > {32'd0, min_interval}) begin
      dt = stamp - last_rot;
      last_rot = stamp;
      if (!have_first) begin
        have_first = 1'b1;
        first_rot = stamp;
        rot_count = '0;
        rep = '{1'b0, '0, '0, '0, stamp};
      end else begin
        if (rot_count != '1)
          rot_count = rot_count + 1'b1;
        rep = '{1'b1, hz_q16(32'd1, dt), hz_q16(rot_count, stamp - first_rot),
                rot_count, stamp};
      end
      pending_reports.push_back(rep);
    end
  endtask

  // Check each report transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_report = '{out_speed_valid, out_instant_hz_q16, out_average_hz_q16,
                     out_rotations, out_rotation_time_ns};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected report at %0t: rotations %0d time %0d",
                   $time, out_rotations, out_rotation_time_ns);
      end else begin
        want_report = pending_reports.pop_front();
        if (got_report.speed_valid !== want_report.speed_valid ||
            got_report.instant_hz_q16 !== want_report.instant_hz_q16 ||
            got_report.average_hz_q16 !== want_report.average_hz_q16 ||
            got_report.rotations !== want_report.rotations ||
            got_report.rotation_time_ns !== want_report.rotation_time_ns) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("report mismatch at %0t", $time);
            $display("  expected: valid %0d inst %0d avg %0d rot %0d time %0d",
                     want_report.speed_valid, want_report.instant_hz_q16,
                     want_report.average_hz_q16, want_report.rotations,
                     want_report.rotation_time_ns);
            $display("  actual:   valid %0d inst %0d avg %0d rot %0d time %0d",
                     got_report.speed_valid, got_report.instant_hz_q16,
                     got_report.average_hz_q16, got_report.rotations,
                     got_report.rotation_time_ns);
          end
        end
      end
    end
  end

  // Offer one interrupt after a random gap; return at the falling edge after the transfer
  task automatic send_irq(input logic [TimeW-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_irq_time_ns <= stamp;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predict_irq(stamp);
    @(negedge clk);
  endtask

  // Pad with a stray even edge when needed, so that the stamp lands on an odd edge
  task automatic send_odd_edge(input logic [TimeW-1:0] stamp);
    if (edge_par)
      send_irq({$urandom, $urandom});
    send_irq(stamp);
  endtask

  // Hold the input, wait for every report, then let the block go quiet
  task automatic drain_reports(input int unsigned tail);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0)
      @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_min_interval(input logic [CfgW-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    min_interval = value;
  endtask

  function automatic logic [TimeW-1:0] random_span();
    case ($urandom_range(2))
      0:       return 64'($urandom_range(1000));
      1:       return 64'($urandom_range(2000000));
      default: return 64'($urandom);
    endcase
  endfunction

  // Reset interval: zero stamp, boundary stamp, then the first rotation
  task automatic test_first_rotation();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_irq(64'd0);
    send_irq(64'd5);
    send_irq(64'd100000000);
    send_irq(64'd7);
    send_irq(64'd100000001);
  endtask

  // Zero interval: rates saturate; instant then sits at, just under, at half the ceiling
  task automatic test_rate_ceiling();
    drain_reports(LATENCY_CYCLES);
    write_min_interval('0);
    send_odd_edge(last_rot + 64'd1);
    send_odd_edge(last_rot + 64'd1);
    send_odd_edge(last_rot + 64'd1000000);
    send_odd_edge(last_rot + 64'd1000001);
    send_odd_edge(last_rot + 64'd2000000);
  endtask

  // Backwards, repeated and boundary stamps dropped at the low interval; one past counts
  task automatic test_rejected_edges();
    drain_reports(LATENCY_CYCLES);
    write_min_interval(MIN_INTERVAL_LOW);
    send_odd_edge(last_rot - 64'd1);
    send_odd_edge(last_rot);
    send_odd_edge(last_rot + 64'(MIN_INTERVAL_LOW));
    send_odd_edge(last_rot + 64'(MIN_INTERVAL_LOW) + 64'd1);
  endtask

  // Widest interval: boundary dropped, one past it counts
  task automatic test_interval_extremes();
    drain_reports(LATENCY_CYCLES);
    write_min_interval(MIN_INTERVAL_HIGH);
    send_odd_edge(last_rot + 64'(MIN_INTERVAL_HIGH));
    send_odd_edge(last_rot + 64'(MIN_INTERVAL_HIGH) + 64'd1);
  endtask

  // Mostly well-formed edge pairs, with near misses, backwards stamps and noise
  task automatic test_random_traffic(input int unsigned n, input logic [CfgW-1:0] interval,
                                     input int unsigned send_pct, input int unsigned recv_pct);
    logic [TimeW-1:0] stamp;
    int unsigned      pick;
    int unsigned      i;
    drain_reports(LATENCY_CYCLES);
    write_min_interval(interval);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n; i++) begin
      if (i == n / 2)
        drain_reports(0);
      pick = $urandom_range(99);
      if (!edge_par) begin
        if (pick < 70)
          stamp = last_rot + {32'd0, min_interval} + 64'd1 + random_span();
        else if (pick < 80)
          stamp = last_rot + {32'd0, min_interval};
        else if (pick < 90)
          stamp = last_rot + (64'($urandom) % ({32'd0, min_interval} + 64'd1));
        else
          stamp = {$urandom, $urandom} % (last_rot + 64'd1);
      end else begin
        if (pick < 80)
          stamp = last_rot + random_span();
        else
          stamp = {$urandom, $urandom};
      end
      send_irq(stamp);
    end
  endtask

  // Climb into the top of the timestamp range, reach the largest stamp, then send noise
  task automatic test_timestamp_ceiling();
    int unsigned i;
    drain_reports(LATENCY_CYCLES);
    write_min_interval(MIN_INTERVAL_LOW);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    send_odd_edge({1'b1, $urandom, 31'($urandom)});
    for (i = 0; i < 6; i++)
      send_odd_edge(last_rot + ((~last_rot) >> $urandom_range(1, 3)));
    send_odd_edge(64'hFFFF_FFFF_FFFF_FFFF);
    for (i = 0; i < 8; i++)
      send_irq({$urandom, $urandom});
  endtask

  initial begin
    // Hold reset from time zero, release at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_first_rotation();
    test_rate_ceiling();
    test_rejected_edges();
    test_interval_extremes();
    test_random_traffic(100, RESET_MIN_INTERVAL_NS, 0, 0);
    test_random_traffic(100, MIN_INTERVAL_LOW, 50, 0);
    test_random_traffic(100, $urandom_range(32'hFFFF_FFFF, 32'd1000000), 0, 50);
    test_random_traffic(100, MIN_INTERVAL_HIGH, 22, 22);
    test_random_traffic(100, $urandom_range(999999), 50, 50);
    test_timestamp_ceiling();

    drain_reports(LATENCY_CYCLES);
    mismatches += pending_reports.size();
    if (mismatches == 0)
      $display("wheel_speed_tachometer regression: pass");
    else
      $display("wheel_speed_tachometer regression: fail");
    $finish;
  end

endmodule
